// ===== src/fvnh_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the fractal value noise height block
// no dependencies

package fvnh_pkg;

	localparam int GRID_DIM = 4096;
	localparam int GRID_W   = 12;
	localparam int STEP_W   = 16;
	localparam int POS_W    = GRID_W + STEP_W;
	localparam int ACC_W    = 40;

	localparam logic [31:0] HASH_ZMUL = 32'd57;
	localparam logic [31:0] HASH_SMUL = 32'd131;
	localparam logic [31:0] HASH_C1   = 32'd15731;
	localparam logic [31:0] HASH_C2   = 32'd789221;
	localparam logic [31:0] HASH_C3   = 32'd1376312589;

	localparam logic [2:0] REG_SEED   = 3'd0;
	localparam logic [2:0] REG_OCT    = 3'd1;
	localparam logic [2:0] REG_STEP   = 3'd2;
	localparam logic [2:0] REG_HSCALE = 3'd3;
	localparam logic [2:0] REG_BASE   = 3'd4;

	typedef struct packed {
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] pz;
	} coord_t;

	typedef struct packed {
		logic [3:0]  pt;
		logic [2:0]  oct_idx;
		logic        last;
		logic [15:0] fx;
		logic [15:0] fz;
	} tag_t;

endpackage

// ===== src/fractal_value_noise_height.sv =====
`timescale 1ns / 1ps
// top level: register port, front queue, octave back end and normalizer
// depends on fvnh_pkg, fvnh_front, fvnh_back, fvnh_norm

// Terrain column height from fractal value noise. An item (grid_x, grid_z) is taken
// when start is high and busy is low; busy rises only while the two-entry input queue
// is full. The back end runs one pipelined lattice hash unit that evaluates 16 lattice
// points per octave, one per cycle; the next item is taken from the queue while the
// last lattice point of the previous item is issued. Each result is shown on
// terrain_height for one cycle with done high; the receiver cannot stall it and must
// take it in that cycle. Registers must be written through the APB port only while
// the block is idle; the block itself does not enforce this.

module fractal_value_noise_height (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [fvnh_pkg::GRID_W-1:0]   grid_x,
	input  logic [fvnh_pkg::GRID_W-1:0]   grid_z,
	output logic                          done,
	output logic signed [7:0]             terrain_height,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [4:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic signed [31:0]  seed_q;
	logic [3:0]          oct_q;
	logic [15:0]         step_q;
	logic [5:0]          hscale_q, base_q;
	logic [3:0]          oct_eff;
	logic                wr_en;
	logic [2:0]          reg_idx;
	logic                head_valid, pop, sum_valid;
	fvnh_pkg::coord_t    head;
	logic signed [fvnh_pkg::ACC_W-1:0] sum_total;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_comb begin
		if (oct_q == 4'd0) begin
			oct_eff = 4'd1;
		end else if (oct_q > 4'd8) begin
			oct_eff = 4'd8;
		end else begin
			oct_eff = oct_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= '0;
			oct_q    <= 4'd4;
			step_q   <= 16'd3277;
			hscale_q <= 6'd30;
			base_q   <= 6'd3;
		end else if (wr_en) begin
			case (reg_idx)
				fvnh_pkg::REG_SEED:   seed_q   <= $signed(pwdata);
				fvnh_pkg::REG_OCT:    oct_q    <= pwdata[3:0];
				fvnh_pkg::REG_STEP:   step_q   <= pwdata[15:0];
				fvnh_pkg::REG_HSCALE: hscale_q <= pwdata[5:0];
				fvnh_pkg::REG_BASE:   base_q   <= pwdata[5:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			fvnh_pkg::REG_SEED:   prdata = seed_q;
			fvnh_pkg::REG_OCT:    prdata = 32'(oct_q);
			fvnh_pkg::REG_STEP:   prdata = 32'(step_q);
			fvnh_pkg::REG_HSCALE: prdata = 32'(hscale_q);
			fvnh_pkg::REG_BASE:   prdata = 32'(base_q);
			default:              prdata = '0;
		endcase
	end

	fvnh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.grid_x     (grid_x),
		.grid_z     (grid_z),
		.coord_step (step_q),
		.full       (busy),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	fvnh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.seed       (seed_q),
		.last_oct   (3'(oct_eff - 4'd1)),
		.sum_valid  (sum_valid),
		.sum_total  (sum_total)
	);

	fvnh_norm u_norm (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (sum_valid),
		.in_total     (sum_total),
		.height_scale (hscale_q),
		.oct_count    (oct_eff),
		.base_height  (base_q),
		.done         (done),
		.height       (terrain_height)
	);

endmodule

// ===== src/fvnh_front.sv =====
`timescale 1ns / 1ps
// front end: takes items, scales the grid coordinate, holds them in a two-entry queue
// depends on fvnh_pkg

module fvnh_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fvnh_pkg::GRID_W-1:0]   grid_x,
	input  logic [fvnh_pkg::GRID_W-1:0]   grid_z,
	input  logic [fvnh_pkg::STEP_W-1:0]   coord_step,
	output logic                          full,
	output logic                          head_valid,
	output fvnh_pkg::coord_t              head,
	input  logic                          pop
);

	fvnh_pkg::coord_t             entry_q [2];
	logic                         wr_ptr_q, rd_ptr_q;
	logic [1:0]                   count_q;
	logic                         push;
	logic [fvnh_pkg::GRID_W-1:0]  gx, gz;
	fvnh_pkg::coord_t             new_entry;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];
	assign push       = start && !full;

	always_comb begin
		gx = fvnh_pkg::GRID_W'(32'(grid_x) % fvnh_pkg::GRID_DIM);
		gz = fvnh_pkg::GRID_W'(32'(grid_z) % fvnh_pkg::GRID_DIM);
		new_entry.px = fvnh_pkg::POS_W'(gx) * fvnh_pkg::POS_W'(coord_step);
		new_entry.pz = fvnh_pkg::POS_W'(gz) * fvnh_pkg::POS_W'(coord_step);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== src/fvnh_hash.sv =====
`timescale 1ns / 1ps
// five-stage pipelined lattice hash, gives the signed q1.30 lattice value
// depends on fvnh_pkg

module fvnh_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [31:0]         in_n,
	input  fvnh_pkg::tag_t      in_tag,
	output logic                out_valid,
	output logic signed [31:0]  out_val,
	output fvnh_pkg::tag_t      out_tag
);

	logic [4:0]      v_q;
	fvnh_pkg::tag_t  tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [31:0]     n_s1, n_s2, n_s3;
	logic [31:0]     sq_s2, t_s3, p_s4;
	logic signed [31:0] val_s5;
	logic [31:0]     h;

	assign h = (p_s4 + fvnh_pkg::HASH_C3) & 32'h7fffffff;

	always_ff @(posedge clk) begin
		n_s1   <= (in_n << 13) ^ in_n;
		tag_s1 <= in_tag;
		n_s2   <= n_s1;
		sq_s2  <= n_s1 * n_s1;
		tag_s2 <= tag_s1;
		n_s3   <= n_s2;
		t_s3   <= sq_s2 * fvnh_pkg::HASH_C1 + fvnh_pkg::HASH_C2;
		tag_s3 <= tag_s2;
		p_s4   <= n_s3 * t_s3;
		tag_s4 <= tag_s3;
		val_s5 <= $signed(32'h40000000 - h);
		tag_s5 <= tag_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[3:0], in_valid};
		end
	end

	assign out_valid = v_q[4];
	assign out_val   = val_s5;
	assign out_tag   = tag_s5;

endmodule

// ===== src/fvnh_back.sv =====
`timescale 1ns / 1ps
// back end: octave sequencer, 4x4 lattice window, smoothing, bilinear blend, octave sum
// depends on fvnh_pkg and fvnh_hash

module fvnh_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               head_valid,
	input  fvnh_pkg::coord_t                   head,
	output logic                               pop,
	input  logic [31:0]                        seed,
	input  logic [2:0]                         last_oct,
	output logic                               sum_valid,
	output logic signed [fvnh_pkg::ACC_W-1:0]  sum_total
);

	logic                           active_q;
	logic [2:0]                     oct_q;
	logic [3:0]                     pt_q;
	logic [fvnh_pkg::POS_W-1:0]     px_q, pz_q;
	logic [fvnh_pkg::POS_W+6:0]     qx, qz;
	logic [31:0]                    cx, cz, hn;
	fvnh_pkg::tag_t                 itag;

	logic                           h_valid;
	logic signed [31:0]             h_val;
	fvnh_pkg::tag_t                 h_tag;

	logic signed [31:0]             win_q [16];
	logic signed [31:0]             w_s1 [16];
	fvnh_pkg::tag_t                 tag_s1, tag_s2, tag_s3, tag_s4;
	logic                           v_s1, v_s2, v_s3, v_s4;
	logic signed [35:0]             sacc [4];
	logic signed [35:0]             term;
	logic signed [31:0]             sm_s2 [4];
	logic signed [31:0]             r0_s3, r1_s3, nv_s4;
	logic signed [fvnh_pkg::ACC_W-1:0] acc_q, acc_new;

	function automatic logic signed [31:0] lerp16(input logic signed [31:0] a,
			input logic signed [31:0] b, input logic [15:0] f);
		logic signed [17:0] wa, wb;
		logic signed [50:0] s;
		wb = $signed({2'b0, f});
		wa = 18'sh10000 - wb;
		s  = 51'(a) * 51'(wa) + 51'(b) * 51'(wb);
		return 32'(s >>> 16);
	endfunction

	// next item may start in the cycle that issues the final point
	assign pop = head_valid && (!active_q || (pt_q == 4'd15 && oct_q == last_oct));

	always_comb begin
		qx = (fvnh_pkg::POS_W+7)'(px_q) << oct_q;
		qz = (fvnh_pkg::POS_W+7)'(pz_q) << oct_q;
		cx = 32'(qx[fvnh_pkg::POS_W+6:16]) + 32'(pt_q[1:0]) - 32'd1;
		cz = 32'(qz[fvnh_pkg::POS_W+6:16]) + 32'(pt_q[3:2]) - 32'd1;
		hn = cx + cz * fvnh_pkg::HASH_ZMUL + seed * fvnh_pkg::HASH_SMUL;
		itag.pt      = pt_q;
		itag.oct_idx = oct_q;
		itag.last    = (oct_q == last_oct);
		itag.fx      = qx[15:0];
		itag.fz      = qz[15:0];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			px_q <= head.px;
			pz_q <= head.pz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			oct_q    <= '0;
			pt_q     <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			oct_q    <= '0;
			pt_q     <= '0;
		end else if (active_q) begin
			pt_q <= pt_q + 4'd1;
			if (pt_q == 4'd15) begin
				if (oct_q == last_oct) begin
					active_q <= 1'b0;
				end else begin
					oct_q <= oct_q + 3'd1;
				end
			end
		end
	end

	fvnh_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (active_q),
		.in_n      (hn),
		.in_tag    (itag),
		.out_valid (h_valid),
		.out_val   (h_val),
		.out_tag   (h_tag)
	);

	// window capture and snapshot once the sixteenth point lands
	always_ff @(posedge clk) begin
		if (h_valid) begin
			win_q[h_tag.pt] <= h_val;
		end
		if (h_valid && h_tag.pt == 4'd15) begin
			for (int k = 0; k < 15; k++) begin
				w_s1[k] <= win_q[k];
			end
			w_s1[15] <= h_val;
			tag_s1   <= h_tag;
		end
	end

	// 3x3 smoothing around each of the four cell corners
	always_comb begin
		term = '0;
		for (int c = 0; c < 4; c++) begin
			sacc[c] = '0;
			for (int dz = 0; dz < 3; dz++) begin
				for (int dx = 0; dx < 3; dx++) begin
					term = 36'(w_s1[((c / 2) + dz) * 4 + (c % 2) + dx]);
					if (dx == 1) begin
						term = term <<< 1;
					end
					if (dz == 1) begin
						term = term <<< 1;
					end
					sacc[c] = sacc[c] + term;
				end
			end
		end
	end

	assign acc_new = (tag_s4.oct_idx == 3'd0 ? '0 : acc_q)
		+ ((fvnh_pkg::ACC_W)'(nv_s4) <<< (~tag_s4.oct_idx));

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			sm_s2[c] <= 32'(sacc[c] >>> 4);
		end
		tag_s2 <= tag_s1;
		r0_s3  <= lerp16(sm_s2[0], sm_s2[1], tag_s2.fx);
		r1_s3  <= lerp16(sm_s2[2], sm_s2[3], tag_s2.fx);
		tag_s3 <= tag_s2;
		nv_s4  <= lerp16(r0_s3, r1_s3, tag_s3.fz);
		tag_s4 <= tag_s3;
		if (v_s4) begin
			acc_q <= acc_new;
		end
		if (v_s4 && tag_s4.last) begin
			sum_total <= acc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			sum_valid <= 1'b0;
		end else begin
			v_s1      <= h_valid && h_tag.pt == 4'd15;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			sum_valid <= v_s4 && tag_s4.last;
		end
	end

endmodule

// ===== src/fvnh_norm.sv =====
`timescale 1ns / 1ps
// normalizer: scales the octave sum, floor-divides by the weight total, adds the offset
// depends on fvnh_pkg

module fvnh_norm (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [fvnh_pkg::ACC_W-1:0]  in_total,
	input  logic [5:0]                         height_scale,
	input  logic [3:0]                         oct_count,
	input  logic [5:0]                         base_height,
	output logic                               done,
	output logic signed [7:0]                  height
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LOAD = 3'b010,
		S_RUN  = 3'b100
	} state_t;

	state_t                                 state_q;
	logic signed [fvnh_pkg::ACC_W+6:0]      prod_q;
	logic signed [16:0]                     y;
	logic [7:0]                             wv, w_q, rem_q, lo_q, rem_n;
	logic [15:0]                            dvd;
	logic [8:0]                             trial;
	logic                                   qbit;
	logic [2:0]                             cnt_q;

	always_comb begin
		y     = 17'(prod_q >>> 30);
		wv    = 8'(9'd256 - (9'd1 << (4'd8 - oct_count)));
		dvd   = 16'(y + $signed({3'b0, wv, 6'b0}));
		trial = {rem_q, lo_q[7]};
		qbit  = (trial >= {1'b0, w_q});
		rem_n = qbit ? 8'(trial - {1'b0, w_q}) : trial[7:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			prod_q <= (fvnh_pkg::ACC_W+7)'(in_total)
				* (fvnh_pkg::ACC_W+7)'($signed({1'b0, height_scale}));
		end
		if (state_q == S_LOAD) begin
			rem_q <= dvd[15:8];
			lo_q  <= dvd[7:0];
			w_q   <= wv;
		end
		if (state_q == S_RUN) begin
			rem_q <= rem_n;
			lo_q  <= {lo_q[6:0], qbit};
		end
		if (state_q == S_RUN && cnt_q == 3'd7) begin
			height <= $signed(8'({2'b0, base_height}) + {lo_q[6:0], qbit} - 8'd64);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for fractal_value_noise_height: directed table then random columns,
// checked against an in-bench height predictor; depends on fvnh_pkg and the block

module tb_top;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [11:0] grid_x = '0;
	logic [11:0] grid_z = '0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	wire busy, done, pready;
	wire signed [7:0] terrain_height;
	wire [31:0] prdata;

	fractal_value_noise_height dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.grid_x(grid_x), .grid_z(grid_z), .done(done),
		.terrain_height(terrain_height), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	logic [31:0] m_seed;
	logic [3:0] m_oct;
	logic [15:0] m_step;
	logic [5:0] m_hscale, m_base;

	logic [7:0] height_q[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_idle = 0;
	bit timed_out = 0;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	function automatic longint lattice_val(input logic [31:0] cx, input logic [31:0] cz);
		logic [31:0] n, h;
		n = cx + cz * fvnh_pkg::HASH_ZMUL + m_seed * fvnh_pkg::HASH_SMUL;
		n = (n << 13) ^ n;
		h = (n * (n * n * fvnh_pkg::HASH_C1 + fvnh_pkg::HASH_C2) + fvnh_pkg::HASH_C3)
			& 32'h7fffffff;
		return longint'(1073741824) - longint'({32'd0, h});
	endfunction

	function automatic longint smooth_val(input logic [31:0] cx, input logic [31:0] cz);
		longint d, s, m;
		d = lattice_val(cx - 1, cz - 1) + lattice_val(cx + 1, cz - 1)
			+ lattice_val(cx - 1, cz + 1) + lattice_val(cx + 1, cz + 1);
		s = lattice_val(cx - 1, cz) + lattice_val(cx + 1, cz)
			+ lattice_val(cx, cz - 1) + lattice_val(cx, cz + 1);
		m = lattice_val(cx, cz);
		return (d + 2 * s + 4 * m) >>> 4;
	endfunction

	function automatic longint blend16(input longint a, input longint b, input longint f);
		return (a * (65536 - f) + b * f) >>> 16;
	endfunction

	function automatic logic [7:0] predict_height(input logic [11:0] gx, input logic [11:0] gz);
		logic [63:0] px, pz, qx, qz;
		logic [31:0] cx, cz;
		longint fx, fz, r0, r1, nv, total, w, num, den, q;
		int oct;
		px = 64'(gx) * 64'(m_step);
		pz = 64'(gz) * 64'(m_step);
		oct = m_oct;
		if (oct < 1) oct = 1;
		if (oct > 8) oct = 8;
		total = 0;
		for (int i = 0; i < oct; i++) begin
			qx = px << i;
			qz = pz << i;
			cx = qx[47:16];
			cz = qz[47:16];
			fx = longint'(qx[15:0]);
			fz = longint'(qz[15:0]);
			r0 = blend16(smooth_val(cx, cz), smooth_val(cx + 1, cz), fx);
			r1 = blend16(smooth_val(cx, cz + 1), smooth_val(cx + 1, cz + 1), fx);
			nv = blend16(r0, r1, fz);
			total += nv * (longint'(1) << (7 - i));
		end
		w = (longint'(1) << 8) - (longint'(1) << (8 - oct));
		num = total * longint'(m_hscale);
		den = w * (longint'(1) << 30);
		q = num / den;
		if ((num % den) != 0 && num < 0) q--;
		return 8'(longint'(m_base) + q);
	endfunction

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			fvnh_pkg::REG_SEED: m_seed = val;
			fvnh_pkg::REG_OCT: m_oct = val[3:0];
			fvnh_pkg::REG_STEP: m_step = val[15:0];
			fvnh_pkg::REG_HSCALE: m_hscale = val[5:0];
			default: m_base = val[5:0];
		endcase
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (height_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_all(input logic [31:0] s, input logic [3:0] o, input logic [15:0] st,
			input logic [5:0] hs, input logic [5:0] b);
		wait_idle();
		reg_write(fvnh_pkg::REG_SEED, s);
		reg_write(fvnh_pkg::REG_OCT, {28'd0, o});
		reg_write(fvnh_pkg::REG_STEP, {16'd0, st});
		reg_write(fvnh_pkg::REG_HSCALE, {26'd0, hs});
		reg_write(fvnh_pkg::REG_BASE, {26'd0, b});
	endtask

	// one item: drive start, hold until accepted; start drops only while idling
	task automatic send_item(input logic [11:0] x, input logic [11:0] z);
		while ($urandom_range(99) < send_idle) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1; grid_x <= x; grid_z <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
		height_q.push_back(predict_height(x, z));
	endtask

	always @(posedge clk) begin
		if (done) begin
			idle_cycles <= 0;
			if (height_q.size() == 0) report("unexpected item", terrain_height, 0);
			else begin
				if (terrain_height !== height_q[0])
					report("terrain_height", terrain_height, $signed(height_q[0]));
				void'(height_q.pop_front());
			end
		end else if (start && !busy) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) timed_out = 1;
	end

	always @(posedge clk) if (timed_out) begin
		$display("TB_ERROR");
		$finish;
	end

	typedef struct {
		logic [11:0] x, z;
		bit fixed;
		logic [7:0] want;
	} dir_row_t;

	dir_row_t dir_tab[] = '{
		'{12'd0, 12'd0, 0, 8'd0}, '{12'd4095, 12'd4095, 0, 8'd0},
		'{12'd4095, 12'd0, 0, 8'd0}, '{12'd0, 12'd4095, 0, 8'd0},
		'{12'd1, 12'd1, 0, 8'd0}, '{12'd20, 12'd20, 0, 8'd0},
		'{12'd2048, 12'd1234, 0, 8'd0}, '{12'd2730, 12'd1365, 0, 8'd0}
	};

	initial begin
		m_seed = 0; m_oct = 4; m_step = 3277; m_hscale = 30; m_base = 3;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) send_item(dir_tab[i].x, dir_tab[i].z);
		// zero scale: height is base only
		set_all(32'h7fffffff, 4'd0, 16'd0, 6'd0, 6'd63);
		for (int i = 0; i < 4; i++) begin
			send_item(dir_tab[i].x, dir_tab[i].z);
			if (height_q[$] !== 8'd63) report("base only", $signed(height_q[$]), 63);
		end
		set_all(32'h80000000, 4'd15, 16'd65535, 6'd63, 6'd0);
		foreach (dir_tab[i]) send_item(dir_tab[i].x, dir_tab[i].z);
		set_all(32'hffffffff, 4'd8, 16'd1, 6'd63, 6'd63);
		foreach (dir_tab[i]) send_item(dir_tab[i].x, dir_tab[i].z);
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 32 : (ph == 1) ? 75 : 0;
			for (int k = 0; k < 5; k++) begin
				set_all($urandom, 4'($urandom_range(1, 4)), 16'($urandom),
					6'($urandom), 6'($urandom));
				for (int j = 0; j < 100; j++) begin
					send_item(12'($urandom), 12'($urandom));
					if (j == 50) wait_idle();
				end
			end
		end
		set_all($urandom, 4'd8, 16'($urandom), 6'($urandom), 6'($urandom));
		for (int j = 0; j < 20; j++) send_item(12'($urandom), 12'($urandom));
		wait_idle();
		repeat (200) @(posedge clk);
		if (errors == 0 && height_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
